### rtl/ctlp_pkg.sv
// shared types, record codes and limits for the configuration trailer tlv parser
package ctlp_pkg;

  // list and string limits
  localparam int unsigned MaxIinEntries  = 16;
  localparam int unsigned MaxPlmnEntries = 16;
  localparam int unsigned CarrierBytes   = 64;
  localparam int unsigned LongIinBytes   = 256;

  // magic at offsets 8 to 15, first character in the top byte
  localparam logic [63:0] MagicWord = 64'h4D43_4647_5F54_524C;

  // record type codes
  localparam logic [7:0] TYPE_END     = 8'h00;
  localparam logic [7:0] TYPE_OEMVER  = 8'h01;
  localparam logic [7:0] TYPE_CARRIER = 8'h03;
  localparam logic [7:0] TYPE_IIN     = 8'h04;
  localparam logic [7:0] TYPE_QCVER   = 8'h05;
  localparam logic [7:0] TYPE_PLMN    = 8'h06;
  localparam logic [7:0] TYPE_CAPAB   = 8'h07;
  localparam logic [7:0] TYPE_LONGIIN = 8'h09;

  // result kinds
  localparam logic [3:0] KIND_CARRIER_CHAR = 4'd0;
  localparam logic [3:0] KIND_CARRIER_END  = 4'd1;
  localparam logic [3:0] KIND_LONGIIN_CHAR = 4'd2;
  localparam logic [3:0] KIND_LONGIIN_END  = 4'd3;
  localparam logic [3:0] KIND_IIN_HEAD     = 4'd4;
  localparam logic [3:0] KIND_IIN          = 4'd5;
  localparam logic [3:0] KIND_PLMN_HEAD    = 4'd6;
  localparam logic [3:0] KIND_PLMN         = 4'd7;
  localparam logic [3:0] KIND_QCVER        = 4'd8;
  localparam logic [3:0] KIND_OEMVER       = 4'd9;
  localparam logic [3:0] KIND_CAPAB        = 4'd10;
  localparam logic [3:0] KIND_STATUS       = 4'd11;

  // status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MALFORM  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  idx;
    logic [31:0] value;
    logic [15:0] mnc;
    logic        wild;
    logic [1:0]  status;
    logic        eor;
  } ctlp_result_t;

  // up to two results made by one byte, record result first
  typedef struct packed {
    logic         a_vld;
    ctlp_result_t a;
    logic         b_vld;
    ctlp_result_t b;
  } ctlp_push_t;

endpackage

### rtl/config_trailer_tlv_parser.sv
// top level of the configuration trailer tlv record parser
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/tready         tdata: data_byte
//   m_axis    out  m_axis_tvalid/tready         tdata/tuser/tlast: one result record
//   cfg       in   cfg_we_i (no wait)           cfg_wdata_i: region_length
//
// one byte per cycle while the result queue has room: a byte is held in the input register and is
// decoded in a single pass into a four-entry result queue, so a result is offered once its byte
// has passed the input register and been written into the queue. a byte can make two results
// (record and status), the queue drains one per cycle while the receiver is ready. the input
// stalls when the queue has fewer than two free entries. reset and a register write
// both restart the parse at the magic check.
module config_trailer_tlv_parser import ctlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,     // region_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,    // [7:0] entry_index, [39:8] record_value,
                                       // [55:40] network_code, [56] wildcard_flag,
                                       // [58:57] parse_status, [63:59] zero
  output logic [3:0]  m_axis_tuser,    // [3:0] record_kind
  output logic        m_axis_tlast     // end_of_region
);

  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  logic         room;
  logic         fire;
  ctlp_push_t   push;
  ctlp_result_t head;

  assign fire          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  ctlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (fire),
    .byte_i      (in_byte_q),
    .push_o      (push)
  );

  ctlp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  // result packing
  assign m_axis_tdata = {5'd0, head.status, head.wild, head.mnc, head.value, head.idx};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.eor;

endmodule

### rtl/ctlp_core.sv
// per-byte parse state and the single-pass record decoder
module ctlp_core import ctlp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output ctlp_push_t  push_o
);

  localparam logic [1:0] PH_MAGIC = 2'd0;
  localparam logic [1:0] PH_HEAD  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_SKIP  = 2'd3;

  logic [19:0] region_q;
  logic [19:0] pos_q, pos_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] off_q, off_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [1:0]  err_q, err_d;
  ctlp_push_t  push;

  // decode one byte against the current state
  always_comb begin
    logic [20:0]  pos_inc;
    logic [20:0]  rem;
    logic [15:0]  hlen;
    logic [16:0]  off_inc;
    logic [15:0]  rel;
    logic [1:0]   k;
    logic [31:0]  acc_new;
    logic [16:0]  need;
    logic [7:0]   maxc;
    logic         failed;
    logic         is_str;
    logic         is_list;
    logic         is_carrier;
    logic [16:0]  cap;

    pos_d   = pos_q;
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    off_d   = off_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    push    = '0;

    pos_inc    = {1'b0, pos_q} + 21'd1;
    rem        = ({1'b0, region_q} > pos_inc) ? ({1'b0, region_q} - pos_inc) : 21'd0;
    hlen       = {byte_i, len_q[7:0]};
    off_inc    = {1'b0, off_q} + 17'd1;
    rel        = off_q - 16'd2;
    k          = rel[1:0];
    acc_new    = '0;
    failed     = 1'b0;
    is_carrier = (type_q == TYPE_CARRIER);
    is_str     = is_carrier || (type_q == TYPE_LONGIIN);
    is_list    = (type_q == TYPE_IIN) || (type_q == TYPE_PLMN);
    cap        = is_carrier ? 17'(CarrierBytes) : 17'(LongIinBytes);
    maxc       = (type_q == TYPE_IIN) ? 8'(MaxIinEntries) : 8'(MaxPlmnEntries);
    need       = {7'd0, byte_i, 2'b00} + 17'd2;

    if (step_i && region_q != '0) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (pos_q >= 20'd8 && pos_q < 20'd16 &&
              byte_i != MagicWord[{~pos_q[2:0], 3'b000} +: 8]) begin
            err_d   = STAT_MALFORM;
            phase_d = PH_SKIP;
          end else if (pos_q >= 20'd15) begin
            phase_d = PH_HEAD;
            off_d   = '0;
          end
        end
        PH_HEAD: begin
          if (off_q == 16'd0) begin
            type_d = byte_i;
            off_d  = 16'd1;
          end else if (off_q == 16'd1) begin
            len_d = {8'd0, byte_i};
            off_d = 16'd2;
          end else begin
            // header complete: check the record against region and limits
            len_d = hlen;
            off_d = '0;
            if ({5'd0, hlen} > rem) begin
              if (type_q == TYPE_END) begin
                phase_d = PH_SKIP;
              end else begin
                err_d   = STAT_MALFORM;
                phase_d = PH_SKIP;
              end
            end else if (is_str && {1'b0, hlen} >= cap) begin
              err_d   = STAT_OVERFLOW;
              phase_d = PH_SKIP;
            end else if (is_str && hlen == '0) begin
              push.a_vld = 1'b1;
              push.a.kind = is_carrier ? KIND_CARRIER_END : KIND_LONGIIN_END;
              phase_d = PH_HEAD;
            end else if (is_list && hlen < 16'd2) begin
              err_d   = STAT_MALFORM;
              phase_d = PH_SKIP;
            end else begin
              phase_d = (hlen == '0) ? PH_HEAD : PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          if (is_str) begin
            push.a_vld  = 1'b1;
            push.a.value = {24'd0, byte_i};
            if (off_inc == {1'b0, len_q}) begin
              push.a.kind = is_carrier ? KIND_CARRIER_END : KIND_LONGIIN_END;
              push.a.idx  = len_q[7:0];
            end else begin
              push.a.kind = is_carrier ? KIND_CARRIER_CHAR : KIND_LONGIIN_CHAR;
              push.a.idx  = off_q[7:0];
            end
          end else if (is_list) begin
            if (off_q == 16'd0) begin
              acc_d = {24'd0, byte_i};
            end else if (off_q == 16'd1) begin
              // list head: entry count and wildcard marker
              if (byte_i > maxc || {1'b0, len_q} < need) begin
                failed  = 1'b1;
                err_d   = STAT_OVERFLOW;
                phase_d = PH_SKIP;
              end else begin
                cnt_d       = byte_i;
                push.a_vld  = 1'b1;
                push.a.kind = (type_q == TYPE_IIN) ? KIND_IIN_HEAD : KIND_PLMN_HEAD;
                push.a.value = {24'd0, byte_i};
                push.a.wild = (acc_q == 32'd1);
              end
            end else if (rel < {6'd0, cnt_q, 2'b00}) begin
              // little-endian entry assembly
              acc_new = (k == 2'd0) ? 32'd0 : acc_q;
              acc_new = acc_new | ({24'd0, byte_i} << {k, 3'b000});
              acc_d   = acc_new;
              if (k == 2'd3) begin
                push.a_vld = 1'b1;
                push.a.idx = rel[9:2];
                if (type_q == TYPE_IIN) begin
                  push.a.kind  = KIND_IIN;
                  push.a.value = acc_new;
                end else begin
                  push.a.kind  = KIND_PLMN;
                  push.a.value = {16'd0, acc_new[15:0]};
                  push.a.mnc   = acc_new[31:16];
                end
              end
            end
          end else if ((type_q == TYPE_OEMVER || type_q == TYPE_QCVER ||
                        type_q == TYPE_CAPAB) && len_q == 16'd4) begin
            acc_new = (off_q == 16'd0) ? 32'd0 : acc_q;
            acc_new = acc_new | ({24'd0, byte_i} << {off_q[1:0], 3'b000});
            acc_d   = acc_new;
            if (off_q == 16'd3) begin
              push.a_vld   = 1'b1;
              push.a.value = acc_new;
              if (type_q == TYPE_QCVER) begin
                push.a.kind = KIND_QCVER;
              end else if (type_q == TYPE_OEMVER) begin
                push.a.kind = KIND_OEMVER;
              end else begin
                push.a.kind = KIND_CAPAB;
              end
            end
          end
          if (!failed) begin
            if (off_inc >= {1'b0, len_q}) begin
              phase_d = PH_HEAD;
              off_d   = '0;
            end else begin
              off_d = off_inc[15:0];
            end
          end
        end
        PH_SKIP: begin
        end
        default: begin
        end
      endcase

      // last byte of the region: report and restart
      if (pos_inc >= {1'b0, region_q}) begin
        push.b_vld    = 1'b1;
        push.b.kind   = KIND_STATUS;
        push.b.status = (phase_d == PH_MAGIC) ? STAT_MALFORM : err_d;
        push.b.eor    = 1'b1;
        pos_d   = '0;
        phase_d = PH_MAGIC;
        type_d  = '0;
        len_d   = '0;
        off_d   = '0;
        acc_d   = '0;
        cnt_d   = '0;
        err_d   = STAT_OK;
      end else begin
        pos_d = pos_inc[19:0];
      end
    end
  end

  assign push_o = push;

  // parse state, restarted by a register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= '0;
      pos_q    <= '0;
      phase_q  <= PH_MAGIC;
      type_q   <= '0;
      len_q    <= '0;
      off_q    <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      err_q    <= STAT_OK;
    end else if (cfg_we_i) begin
      region_q <= cfg_wdata_i;
      pos_q    <= '0;
      phase_q  <= PH_MAGIC;
      type_q   <= '0;
      len_q    <= '0;
      off_q    <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      err_q    <= STAT_OK;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      off_q   <= off_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

endmodule

### rtl/ctlp_out_fifo.sv
// four-entry result queue taking up to two results per cycle
module ctlp_out_fifo import ctlp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ctlp_push_t   push_i,
  output logic         room_o,
  output logic         valid_o,
  input  logic         ready_i,
  output ctlp_result_t head_o
);

  ctlp_result_t mem_q [4];
  logic [1:0]   wp_q, wp_d;
  logic [1:0]   rp_q, rp_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         pop;
  logic [2:0]   n_push;

  assign valid_o = (cnt_q != 3'd0);
  assign head_o  = mem_q[rp_q];
  assign room_o  = (cnt_q <= 3'd2);
  assign pop     = valid_o && ready_i;
  assign n_push  = {2'b00, push_i.a_vld} + {2'b00, push_i.b_vld};

  // pointer and fill count update
  always_comb begin
    wp_d  = wp_q + n_push[1:0];
    rp_d  = rp_q + {1'b0, pop};
    cnt_d = cnt_q + n_push - {2'b00, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage, record result ahead of status
  always_ff @(posedge clk_i) begin
    if (push_i.a_vld) begin
      mem_q[wp_q] <= push_i.a;
    end
    if (push_i.b_vld) begin
      mem_q[push_i.a_vld ? wp_q + 2'd1 : wp_q] <= push_i.b;
    end
  end

endmodule

### test/config_trailer_tlv_parser_tb.sv
// self-checking testbench for the configuration trailer tlv parser: random and directed regions
module config_trailer_tlv_parser_tb;
  import ctlp_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomBytes   = 150;
  localparam int unsigned ReportLimit   = 10;

  // parse walk of the byte predictor
  typedef enum logic [1:0] {
    WALK_MAGIC,
    WALK_HEADER,
    WALK_VALUE,
    WALK_DRAIN
  } walk_e;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [19:0] cfg_wdata_i    = '0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata   = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // stimulus and expectation stores
  logic [7:0]   pending_bytes[$];
  logic [7:0]   region_q[$];
  logic [7:0]   body_q[$];
  ctlp_result_t expected_records[$];

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_mode      = 0;
  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;

  // predictor state
  logic [19:0] region_len = '0;
  logic [19:0] byte_pos   = '0;
  walk_e       walk       = WALK_MAGIC;
  logic [7:0]  rec_type   = '0;
  logic [15:0] rec_len    = '0;
  logic [15:0] val_off    = '0;
  logic [31:0] acc        = '0;
  logic [7:0]  entries    = '0;
  logic [1:0]  err        = STAT_OK;

  config_trailer_tlv_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void expect_record(logic [3:0] kind, logic [7:0] idx, logic [31:0] value,
                                        logic [15:0] mnc, logic wild, logic [1:0] status,
                                        logic eor);
    ctlp_result_t r;
    r.kind   = kind;
    r.idx    = idx;
    r.value  = value;
    r.mnc    = mnc;
    r.wild   = wild;
    r.status = status;
    r.eor    = eor;
    expected_records.push_back(r);
  endfunction

  function automatic void restart_walk();
    byte_pos = '0;
    walk     = WALK_MAGIC;
    rec_type = '0;
    rec_len  = '0;
    val_off  = '0;
    acc      = '0;
    entries  = '0;
    err      = STAT_OK;
  endfunction

  function automatic void abort_walk(logic [1:0] code);
    err  = code;
    walk = WALK_DRAIN;
  endfunction

  // header complete: check the record against the region and its limits
  function automatic void open_record();
    int unsigned pos1;
    int unsigned rem;
    int unsigned len;
    int unsigned cap;
    pos1    = int'(byte_pos) + 1;
    rem     = (region_len > pos1) ? region_len - pos1 : 0;
    len     = rec_len;
    val_off = '0;
    if (len > rem) begin
      if (rec_type == TYPE_END) walk = WALK_DRAIN;
      else abort_walk(STAT_MALFORM);
      return;
    end
    if (rec_type == TYPE_CARRIER || rec_type == TYPE_LONGIIN) begin
      cap = (rec_type == TYPE_CARRIER) ? CarrierBytes : LongIinBytes;
      if (len >= cap) begin
        abort_walk(STAT_OVERFLOW);
        return;
      end
      if (len == 0) begin
        expect_record((rec_type == TYPE_CARRIER) ? KIND_CARRIER_END : KIND_LONGIIN_END,
                      8'd0, 32'd0, 16'd0, 1'b0, STAT_OK, 1'b0);
        walk = WALK_HEADER;
        return;
      end
    end else if (rec_type == TYPE_IIN || rec_type == TYPE_PLMN) begin
      if (len < 2) begin
        abort_walk(STAT_MALFORM);
        return;
      end
    end
    walk = (len == 0) ? WALK_HEADER : WALK_VALUE;
  endfunction

  // one value byte of the current record
  function automatic void take_value(logic [7:0] b);
    int unsigned o;
    int unsigned len;
    int unsigned maxc;
    int unsigned rel;
    int unsigned lane;
    o   = val_off;
    len = rec_len;
    if (rec_type == TYPE_CARRIER || rec_type == TYPE_LONGIIN) begin
      if (o + 1 == len)
        expect_record((rec_type == TYPE_CARRIER) ? KIND_CARRIER_END : KIND_LONGIIN_END,
                      8'(len), 32'(b), 16'd0, 1'b0, STAT_OK, 1'b0);
      else
        expect_record((rec_type == TYPE_CARRIER) ? KIND_CARRIER_CHAR : KIND_LONGIIN_CHAR,
                      8'(o), 32'(b), 16'd0, 1'b0, STAT_OK, 1'b0);
    end else if (rec_type == TYPE_IIN || rec_type == TYPE_PLMN) begin
      if (o == 0) begin
        acc = 32'(b);
      end else if (o == 1) begin
        maxc = (rec_type == TYPE_IIN) ? MaxIinEntries : MaxPlmnEntries;
        if (int'(b) > maxc || len < 2 + 4 * int'(b)) begin
          abort_walk(STAT_OVERFLOW);
          return;
        end
        entries = b;
        expect_record((rec_type == TYPE_IIN) ? KIND_IIN_HEAD : KIND_PLMN_HEAD, 8'd0, 32'(b),
                      16'd0, acc == 32'd1, STAT_OK, 1'b0);
      end else begin
        rel = o - 2;
        if (rel < 4 * int'(entries)) begin
          lane = rel % 4;
          if (lane == 0) acc = '0;
          acc = acc | (32'(b) << (8 * lane));
          if (lane == 3) begin
            if (rec_type == TYPE_IIN)
              expect_record(KIND_IIN, 8'(rel / 4), acc, 16'd0, 1'b0, STAT_OK, 1'b0);
            else
              expect_record(KIND_PLMN, 8'(rel / 4), {16'd0, acc[15:0]}, acc[31:16], 1'b0,
                            STAT_OK, 1'b0);
          end
        end
      end
    end else if ((rec_type == TYPE_OEMVER || rec_type == TYPE_QCVER ||
                  rec_type == TYPE_CAPAB) && len == 4) begin
      if (o == 0) acc = '0;
      acc = acc | (32'(b) << (8 * (o % 4)));
      if (o == 3)
        expect_record((rec_type == TYPE_QCVER) ? KIND_QCVER :
                      (rec_type == TYPE_OEMVER) ? KIND_OEMVER : KIND_CAPAB,
                      8'd0, acc, 16'd0, 1'b0, STAT_OK, 1'b0);
    end
    if (o + 1 >= len) begin
      walk    = WALK_HEADER;
      val_off = '0;
    end else begin
      val_off = 16'(o + 1);
    end
  endfunction

  // advance the predictor by one accepted byte
  function automatic void parse_byte(logic [7:0] b);
    int unsigned pos;
    logic [7:0]  magic_char;
    if (region_len == 0) return;
    pos        = byte_pos;
    magic_char = '0;
    if (pos >= 8 && pos < 16) magic_char = MagicWord[63 - 8 * (pos - 8) -: 8];
    case (walk)
      WALK_MAGIC: begin
        if (pos >= 8 && pos < 16 && b != magic_char) begin
          abort_walk(STAT_MALFORM);
        end else if (pos >= 15) begin
          walk    = WALK_HEADER;
          val_off = '0;
        end
      end
      WALK_HEADER: begin
        if (val_off == 0) begin
          rec_type = b;
          val_off  = 16'd1;
        end else if (val_off == 1) begin
          rec_len = {8'd0, b};
          val_off = 16'd2;
        end else begin
          rec_len[15:8] = b;
          open_record();
        end
      end
      WALK_VALUE: take_value(b);
      default: ;
    endcase
    if (pos + 1 >= region_len) begin
      if (walk == WALK_MAGIC) err = STAT_MALFORM;
      expect_record(KIND_STATUS, 8'd0, 32'd0, 16'd0, 1'b0, err, 1'b1);
      restart_walk();
    end else begin
      byte_pos = 20'(pos + 1);
    end
  endfunction

  // ---------------------------------------------------------------- driver and monitor

  // byte driver: holds a transfer until accepted, then feeds the predictor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void report_mismatch(string what, ctlp_result_t want, ctlp_result_t got);
    if (fail_count < ReportLimit) begin
      $display("%s: expected kind %0d idx %0d value %h mnc %h wild %b status %0d last %b",
               what, want.kind, want.idx, want.value, want.mnc, want.wild, want.status,
               want.eor);
      $display("  got kind %0d idx %0d value %h mnc %h wild %b status %0d last %b",
               got.kind, got.idx, got.value, got.mnc, got.wild, got.status, got.eor);
    end
    fail_count++;
  endfunction

  // result monitor: compares each transfer with the oldest expectation
  always @(posedge clk_i) begin
    ctlp_result_t got;
    ctlp_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind   = m_axis_tuser;
        got.idx    = m_axis_tdata[7:0];
        got.value  = m_axis_tdata[39:8];
        got.mnc    = m_axis_tdata[55:40];
        got.wild   = m_axis_tdata[56];
        got.status = m_axis_tdata[58:57];
        got.eor    = m_axis_tlast;
        if (expected_records.size() == 0) begin
          want = '0;
          report_mismatch("unexpected record", want, got);
        end else begin
          want = expected_records.pop_front();
          if (got.kind !== want.kind || got.idx !== want.idx || got.value !== want.value ||
              got.mnc !== want.mnc || got.wild !== want.wild ||
              got.status !== want.status || got.eor !== want.eor)
            report_mismatch("record mismatch", want, got);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer or register write
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_records.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // next idling phase: none, sender idle, receiver stalling, both
  task automatic next_idle_mode();
    case (idle_mode % 4)
      0: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_gap_pct   = 66;
        recv_stall_pct = 0;
      end
      2: begin
        send_gap_pct   = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_gap_pct   = 24;
        recv_stall_pct = 24;
      end
    endcase
    idle_mode++;
  endtask

  // region length write, which also restarts the parse
  task automatic set_region_length(int unsigned len);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 20'(len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    region_len  = 20'(len);
    restart_walk();
    @(negedge clk_i);
  endtask

  task automatic add_bytes(int unsigned n);
    repeat (n) region_q.push_back(8'($urandom));
  endtask

  task automatic add_header(logic [7:0] t, int unsigned len);
    region_q.push_back(t);
    region_q.push_back(8'(len));
    region_q.push_back(8'(len >> 8));
  endtask

  // eight ignored bytes then the magic, optionally with one byte spoiled
  task automatic add_magic(bit spoil);
    int unsigned bad;
    add_bytes(8);
    for (int i = 0; i < 8; i++) region_q.push_back(MagicWord[63 - 8 * i -: 8]);
    if (spoil) begin
      bad = $urandom_range(8, 15);
      region_q[bad] = region_q[bad] ^ 8'($urandom_range(1, 255));
    end
  endtask

  function automatic int unsigned pick_string_len(int unsigned cap);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 0;
    if (r < 16) return $urandom_range(cap, cap + 8);
    if (r < 20) return cap - 1;
    if (r < 24) return $urandom_range(cap / 2, cap - 1);
    return $urandom_range(1, (cap - 1 < 20) ? cap - 1 : 20);
  endfunction

  // one random record, mostly well formed
  task automatic add_record();
    int unsigned sel;
    int unsigned r;
    int unsigned len;
    int unsigned cnt;
    logic [7:0]  t;
    sel = $urandom_range(99);
    if (sel < 12) begin
      len = pick_string_len(CarrierBytes);
      add_header(TYPE_CARRIER, len);
      add_bytes(len);
    end else if (sel < 20) begin
      len = pick_string_len(LongIinBytes);
      add_header(TYPE_LONGIIN, len);
      add_bytes(len);
    end else if (sel < 42) begin
      r = $urandom_range(2);
      t = (r == 0) ? TYPE_OEMVER : (r == 1) ? TYPE_QCVER : TYPE_CAPAB;
      len = ($urandom_range(9) == 0) ? $urandom_range(0, 6) : 4;
      add_header(t, len);
      add_bytes(len);
    end else if (sel < 66) begin
      t = $urandom_range(1) ? TYPE_IIN : TYPE_PLMN;
      r = $urandom_range(99);
      if (r < 80) cnt = $urandom_range(0, 4);
      else if (r < 90) cnt = $urandom_range(5, 16);
      else cnt = $urandom_range(17, 255);
      len = 2 + 4 * cnt + $urandom_range(0, 2);
      if ($urandom_range(99) < 8) len = $urandom_range(0, 1 + 4 * cnt);
      add_header(t, len);
      for (int unsigned i = 0; i < len; i++) begin
        if (i == 0) region_q.push_back($urandom_range(1) ? 8'd1 : 8'($urandom));
        else if (i == 1) region_q.push_back(8'(cnt));
        else region_q.push_back(8'($urandom));
      end
    end else if (sel < 82) begin
      // unknown type, value skipped
      do t = 8'($urandom);
      while (t == TYPE_END || t == TYPE_OEMVER || t == TYPE_CARRIER || t == TYPE_IIN ||
             t == TYPE_QCVER || t == TYPE_PLMN || t == TYPE_CAPAB || t == TYPE_LONGIIN);
      len = $urandom_range(0, 6);
      add_header(t, len);
      add_bytes(len);
    end else begin
      // end record: either skipped or overrunning the region
      len = $urandom_range(1) ? $urandom_range(0, 4) : $urandom_range(0, 65535);
      add_header(TYPE_END, len);
      add_bytes((len > 64) ? 0 : len);
    end
  endtask

  task automatic queue_region(int unsigned len);
    for (int unsigned i = 0; i < len && i < region_q.size(); i++)
      pending_bytes.push_back(region_q[i]);
  endtask

  // directed region: magic followed by the prepared record bytes
  task automatic send_body(bit spoil);
    region_q.delete();
    add_magic(spoil);
    foreach (body_q[i]) region_q.push_back(body_q[i]);
    set_region_length(region_q.size());
    next_idle_mode();
    queue_region(region_q.size());
  endtask

  task automatic send_random_region(int unsigned len);
    int unsigned r;
    region_q.delete();
    r = $urandom_range(99);
    if (r < 10) begin
      add_bytes(len);
    end else begin
      add_magic(r < 20);
      while (region_q.size() < len) add_record();
    end
    queue_region(len);
  endtask

  initial begin
    int unsigned sent;
    int unsigned rlen;
    int unsigned r;
    restart_walk();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // zero length after reset: bytes are swallowed
    repeat (4) pending_bytes.push_back(8'($urandom));

    // largest length, never reaching its end; the next write restarts
    set_region_length(20'hFFFFF);
    region_q.delete();
    add_magic(1'b0);
    add_header(TYPE_QCVER, 4);
    add_bytes(5);
    queue_region(region_q.size());

    // single byte region, then explicit zero length
    set_region_length(1);
    pending_bytes.push_back(8'($urandom));
    set_region_length(0);
    repeat (3) pending_bytes.push_back(8'($urandom));

    // magic only, bad magic, short magic
    body_q.delete();
    send_body(1'b0);
    send_body(1'b1);
    set_region_length(12);
    region_q.delete();
    add_magic(1'b0);
    queue_region(12);

    // every record kind, ended cleanly by an overrunning end record
    body_q = '{TYPE_QCVER, 8'd4, 8'd0, 8'h78, 8'h56, 8'h34, 8'h12,
               TYPE_OEMVER, 8'd4, 8'd0, 8'hEF, 8'hBE, 8'hAD, 8'hDE,
               TYPE_CAPAB, 8'd4, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               TYPE_CARRIER, 8'd0, 8'd0, TYPE_LONGIIN, 8'd0, 8'd0,
               TYPE_CARRIER, 8'd2, 8'd0, 8'h61, 8'h62,
               TYPE_IIN, 8'd6, 8'd0, 8'd1, 8'd1, 8'h00, 8'h00, 8'h00, 8'h80,
               TYPE_PLMN, 8'd7, 8'd0, 8'd0, 8'd1, 8'h36, 8'h01, 8'h34, 8'h12, 8'h99,
               TYPE_QCVER, 8'd3, 8'd0, 8'h01, 8'h02, 8'h03,
               8'h42, 8'd2, 8'd0, 8'h00, 8'hFF,
               TYPE_END, 8'd0, 8'd0,
               TYPE_END, 8'hFF, 8'hFF, 8'h11, 8'h22};
    send_body(1'b0);

    // list too short for its head
    body_q = '{TYPE_IIN, 8'd1, 8'd0, 8'hAA, 8'h55};
    send_body(1'b0);
    // list length below its count
    body_q = '{TYPE_PLMN, 8'd6, 8'd0, 8'd1, 8'd2, 8'h01, 8'h02, 8'h03, 8'h04};
    send_body(1'b0);
    // list count above the maximum
    body_q = '{TYPE_IIN, 8'd70, 8'd0, 8'd0, 8'd17};
    repeat (68) body_q.push_back(8'($urandom));
    send_body(1'b0);
    // carrier string at its limit
    body_q = '{TYPE_CARRIER, 8'd64, 8'd0};
    repeat (64) body_q.push_back(8'($urandom));
    send_body(1'b0);
    // record running past the region
    body_q = '{TYPE_QCVER, 8'd9, 8'd0, 8'h01, 8'h02};
    send_body(1'b0);
    // one and two trailing bytes
    body_q = '{TYPE_CAPAB};
    send_body(1'b0);
    body_q = '{TYPE_CAPAB, 8'd4};
    send_body(1'b0);

    // longest strings and fullest lists
    body_q.delete();
    body_q = '{TYPE_CARRIER, 8'd63, 8'd0};
    repeat (63) body_q.push_back(8'($urandom));
    body_q.push_back(TYPE_LONGIIN);
    body_q.push_back(8'd255);
    body_q.push_back(8'd0);
    repeat (255) body_q.push_back(8'($urandom));
    body_q.push_back(TYPE_IIN);
    body_q.push_back(8'd66);
    body_q.push_back(8'd0);
    body_q.push_back(8'($urandom));
    body_q.push_back(8'(MaxIinEntries));
    repeat (64) body_q.push_back(8'($urandom));
    body_q.push_back(TYPE_PLMN);
    body_q.push_back(8'd66);
    body_q.push_back(8'd0);
    body_q.push_back(8'd1);
    body_q.push_back(8'(MaxPlmnEntries));
    repeat (64) body_q.push_back(8'($urandom));
    send_body(1'b0);

    // random regions, cycling through the idling modes
    sent = 0;
    while (sent < RandomBytes) begin
      r = $urandom_range(99);
      if (r < 6) rlen = $urandom_range(300, 450);
      else if (r < 14) rlen = $urandom_range(1, 15);
      else rlen = $urandom_range(16, 120);
      set_region_length(rlen);
      repeat ($urandom_range(1, 3)) begin
        next_idle_mode();
        send_random_region(rlen);
        sent += rlen;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
